// ----- rtl/core/sca_pkg.sv -----
// types, codes and helper functions shared by the size class allocator
`timescale 1ns / 1ps

package sca_pkg;

    localparam int unsigned CLASS_FIELD_W = 4;
    localparam int unsigned SLOT_FIELD_W  = 6;
    localparam int unsigned QUEUE_DEPTH   = 2;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_ADDR = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_TOO_BIG  = 2'd2,
        CMD_BAD_ADDR = 2'd3
    } t_cmd_kind;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_SEARCH = 1'b1
    } t_back_state;

    typedef struct packed {
        t_req_kind   kind;
        logic [15:0] request_bytes;
        logic [16:0] block_address;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [16:0] address;
        logic [3:0]  size_class;
        logic [4:0]  slot;
    } t_rsp;

    // classified request handed from front to back
    typedef struct packed {
        t_cmd_kind                 kind;
        logic [CLASS_FIELD_W-1:0]  cls;
        logic [SLOT_FIELD_W-1:0]   slot;
    } t_cmd;

    // log2 of the slot size of a class
    function automatic logic [3:0] class_shift(logic [3:0] c);
        return (c < 4'd3) ? 4'd3 : c;
    endfunction

    // byte offset of the region of class c
    function automatic logic [31:0] region_base(int unsigned c, int unsigned slots);
        logic [31:0] base;
        base = '0;
        for (int unsigned i = 0; i < c; i++) begin
            base = base + (32'(slots) << class_shift(4'(i)));
        end
        return base;
    endfunction

endpackage

// ----- rtl/core/sca_stream_if.sv -----
// valid / ready channel carrying one request or response
`timescale 1ns / 1ps

interface sca_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/size_class_bitmap_allocator.sv -----
// size class allocator: free and error commands pass the command queue, then load the response register
// allocate: the engine loads the mapped class, then searches upward from it, skipping full classes
// throughput: one free per cycle while the response is not stalled; an allocate holds the
// engine busy for the one-class-per-cycle bitmap search, so no new command is taken meanwhile
// reset: synchronous, clears all bitmaps at once, queue and response empty
`timescale 1ns / 1ps

module size_class_bitmap_allocator #(
    parameter int unsigned SLOTS_PER_CLASS = 32,
    parameter int unsigned NUM_CLASSES     = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sca_stream_if.sink   i_req,
    sca_stream_if.source o_rsp
);
    import sca_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_cmd_valid;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    sca_front #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .NUM_CLASSES     (NUM_CLASSES)
    ) u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    sca_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_head_cmd)
    );

    sca_back #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .NUM_CLASSES     (NUM_CLASSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- rtl/core/sca_front.sv -----
// request front end: size to class mapping and free address region lookup
`timescale 1ns / 1ps

module sca_front #(
    parameter int unsigned SLOTS_PER_CLASS = 32,
    parameter int unsigned NUM_CLASSES     = 11
) (
    sca_stream_if.sink    i_req,
    input  logic          i_full,
    output logic          o_push,
    output sca_pkg::t_cmd o_cmd
);
    import sca_pkg::*;

    localparam int unsigned CLS_W  = $clog2(NUM_CLASSES);
    localparam int unsigned SLOT_W = $clog2(SLOTS_PER_CLASS);

    logic [31:0]      w_base_tab [NUM_CLASSES];
    logic [31:0]      w_end_tab  [NUM_CLASSES];
    logic [15:0]      w_bytes_m1;
    logic [4:0]       w_ceil;
    logic             w_too_big;
    logic [31:0]      w_addr;
    logic             w_found;
    logic [CLS_W-1:0] w_region;
    logic [31:0]      w_offset;

    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_tab
        assign w_base_tab[g] = region_base(g, SLOTS_PER_CLASS);
        assign w_end_tab[g]  = region_base(g + 1, SLOTS_PER_CLASS);
    end

    // ceil(log2(bytes)), with 0 and 1 byte mapping to class 0
    always_comb begin
        w_bytes_m1 = i_req.data.request_bytes - 16'd1;
        w_ceil     = 5'd0;
        if (i_req.data.request_bytes > 16'd1) begin
            for (int i = 0; i < 16; i++) begin
                if (w_bytes_m1[i]) begin
                    w_ceil = 5'(i + 1);
                end
            end
        end
        w_too_big = w_ceil > 5'(NUM_CLASSES - 1);
    end

    // regions are contiguous: first region whose end lies above the address
    always_comb begin
        w_addr   = 32'(i_req.data.block_address);
        w_found  = 1'b0;
        w_region = '0;
        for (int g = NUM_CLASSES - 1; g >= 0; g--) begin
            if (w_addr < w_end_tab[g]) begin
                w_found  = 1'b1;
                w_region = CLS_W'(g);
            end
        end
        w_offset = w_addr - w_base_tab[w_region];
    end

    always_comb begin
        o_cmd = '0;
        if (i_req.data.kind == KIND_ALLOC) begin
            o_cmd.kind = w_too_big ? CMD_TOO_BIG : CMD_ALLOC;
            o_cmd.cls  = w_too_big ? '0 : CLASS_FIELD_W'(w_ceil);
        end else if (w_found) begin
            o_cmd.kind = CMD_FREE;
            o_cmd.cls  = CLASS_FIELD_W'(w_region);
            o_cmd.slot = SLOT_FIELD_W'(SLOT_W'(w_offset >> class_shift(4'(w_region))));
        end else begin
            o_cmd.kind = CMD_BAD_ADDR;
        end
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

endmodule

// ----- rtl/core/sca_cmd_queue.sv -----
// short command queue between front end and bitmap engine
`timescale 1ns / 1ps

module sca_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sca_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sca_pkg::t_cmd o_cmd
);
    import sca_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic [PTR_W:0]   n_count;

    assign o_full  = r_count == (PTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/sca_back.sv -----
// bitmap engine: slot search, bitmap update and response register
`timescale 1ns / 1ps

module sca_back #(
    parameter int unsigned SLOTS_PER_CLASS = 32,
    parameter int unsigned NUM_CLASSES     = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  sca_pkg::t_cmd i_cmd,
    output logic          o_pop,
    sca_stream_if.source  o_rsp
);
    import sca_pkg::*;

    localparam int unsigned CLS_W  = $clog2(NUM_CLASSES);
    localparam int unsigned SLOT_W = $clog2(SLOTS_PER_CLASS);

    logic [31:0]                w_base_tab [NUM_CLASSES];
    logic [SLOTS_PER_CLASS-1:0] r_bitmap   [NUM_CLASSES];

    t_back_state       r_state;
    t_back_state       n_state;
    logic [CLS_W-1:0]  r_k;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    logic [SLOTS_PER_CLASS-1:0] w_occ;
    logic                       w_has_room;
    logic                       w_last;
    logic [SLOT_W-1:0]          w_free_slot;
    logic                       w_out_free;
    logic                       w_load_k;
    logic                       w_inc;
    logic                       w_set;
    logic                       w_clr;
    logic                       w_load_rsp;
    t_status                    w_status;
    logic [CLS_W-1:0]           w_sel_cls;
    logic [SLOT_W-1:0]          w_sel_slot;
    logic [16:0]                w_addr;

    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_tab
        assign w_base_tab[g] = region_base(g, SLOTS_PER_CLASS);
    end

    assign w_out_free = !r_rsp_valid || o_rsp.ready;
    assign w_occ      = r_bitmap[r_k];
    assign w_has_room = !(&w_occ);
    assign w_last     = r_k == CLS_W'(NUM_CLASSES - 1);

    // lowest free slot of the class under search
    always_comb begin
        w_free_slot = '0;
        for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
            if (!w_occ[i]) begin
                w_free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == CMD_ALLOC) begin
                    n_state = BK_SEARCH;
                end
            end
            BK_SEARCH: begin
                if ((w_has_room || w_last) && w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_load_k   = 1'b0;
        w_inc      = 1'b0;
        w_set      = 1'b0;
        w_clr      = 1'b0;
        w_load_rsp = 1'b0;
        w_status   = ST_DONE;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_ALLOC: begin
                            o_pop    = 1'b1;
                            w_load_k = 1'b1;
                        end
                        CMD_FREE: begin
                            o_pop      = w_out_free;
                            w_clr      = w_out_free;
                            w_load_rsp = w_out_free;
                        end
                        CMD_TOO_BIG: begin
                            o_pop      = w_out_free;
                            w_load_rsp = w_out_free;
                            w_status   = ST_TOO_BIG;
                        end
                        CMD_BAD_ADDR: begin
                            o_pop      = w_out_free;
                            w_load_rsp = w_out_free;
                            w_status   = ST_BAD_ADDR;
                        end
                    endcase
                end
            end
            BK_SEARCH: begin
                if (w_has_room) begin
                    w_set      = w_out_free;
                    w_load_rsp = w_out_free;
                end else if (w_last) begin
                    w_load_rsp = w_out_free;
                    w_status   = ST_FULL;
                end else begin
                    w_inc = 1'b1;
                end
            end
        endcase
    end

    // class and slot of the response come from the search or the free command
    always_comb begin
        w_sel_cls  = (r_state == BK_SEARCH) ? r_k : i_cmd.cls[CLS_W-1:0];
        w_sel_slot = (r_state == BK_SEARCH) ? w_free_slot : i_cmd.slot[SLOT_W-1:0];
        w_addr     = 17'(w_base_tab[w_sel_cls]
                         + (32'(w_sel_slot) << class_shift(4'(w_sel_cls))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_bitmap[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (w_set) begin
                r_bitmap[r_k][w_free_slot] <= 1'b1;
            end else if (w_clr) begin
                r_bitmap[i_cmd.cls[CLS_W-1:0]][i_cmd.slot[SLOT_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_k) begin
            r_k <= i_cmd.cls[CLS_W-1:0];
        end else if (w_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (w_load_rsp) begin
            r_rsp.status <= w_status;
            if (w_status == ST_DONE) begin
                r_rsp.address    <= w_addr;
                r_rsp.size_class <= 4'(w_sel_cls);
                r_rsp.slot       <= 5'(w_sel_slot);
            end else begin
                r_rsp.address    <= '0;
                r_rsp.size_class <= '0;
                r_rsp.slot       <= '0;
            end
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SEARCH) |-> (r_k <= CLS_W'(NUM_CLASSES - 1)))
        else $error("search class out of range");

    a_alloc_marks_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_set |=> r_bitmap[$past(r_k)][$past(w_free_slot)])
        else $error("allocated slot not marked in use");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == BK_IDLE) && i_cmd_valid)
        else $error("command taken while busy or queue empty");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.status != ST_DONE) |->
        (r_rsp.address == '0 && r_rsp.size_class == '0 && r_rsp.slot == '0))
        else $error("error response carries nonzero fields");

endmodule
